// ----- hdl/ecc_pkg.sv -----
package ecc_pkg;

	typedef enum logic [1:0] {
		FUNC_SET  = 2'd0,
		FUNC_INC  = 2'd1,
		FUNC_DEC  = 2'd2,
		FUNC_READ = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SET_YEAR,
		CMD_SET_MON,
		CMD_SET_DAY,
		CMD_MUL,
		CMD_SUM,
		CMD_INC,
		CMD_DEC,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_DIV_END,
		CMD_DEC_YEAR,
		CMD_DEC_MON,
		CMD_HOUR,
		CMD_MIN
	} dp_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_YEAR,
		ST_SET_MON,
		ST_MUL,
		ST_SUM,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_END,
		ST_YEAR,
		ST_MON,
		ST_HOUR,
		ST_MIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic set_year_more;
		logic set_mon_more;
		logic year_fit;
		logic mon_fit;
		logic hour_fit;
		logic min_fit;
	} dp_status_t;

	typedef struct packed {
		dp_cmd_t cmd;
		logic    in_ready;
		logic    out_load;
	} ctrl_out_t;

	localparam logic [32:0] COUNT_TOP    = 33'h1_FFFF_FFFF;
	localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
	localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
	localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
	localparam logic [16:0] DAY_SECONDS  = 17'd86400;
	localparam logic [16:0] HOUR_SECONDS = 17'd3600;
	localparam logic [16:0] MIN_SECONDS  = 17'd60;
	// day count = ((count >> 7) * ceil(2^36 / 675)) >> 36, exact for any 33-bit count
	localparam logic [26:0] DAY_RECIP       = 27'd101806633;
	localparam int          DAY_RECIP_SHIFT = 36;

	function automatic logic is_leap(logic [1:0] m4, logic [6:0] m100, logic [8:0] m400);
		return ((m4 == 2'd0) && (m100 != 7'd0)) || (m400 == 9'd0);
	endfunction

	function automatic logic [8:0] year_len(logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
		logic [4:0] len;
		case (m) inside
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- hdl/ecc_datapath.sv -----
module ecc_datapath
	import ecc_pkg::*;
#(
	parameter int YEAR_SPAN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [39:0] set_word,
	output dp_status_t  status,
	output logic [32:0] total_seconds,
	output logic [11:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [4:0]  out_hour,
	output logic [5:0]  out_minute,
	output logic [5:0]  out_second
);

	localparam int SET_DAYS_MAX = YEAR_SPAN * 366 + 400;
	localparam int DAYS_W = ($clog2(SET_DAYS_MAX) > 17) ? $clog2(SET_DAYS_MAX) : 17;
	localparam int PROD_W = DAYS_W + 17;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic [11:0] YEAR_LAST = 12'(1970 + YEAR_SPAN - 1);

	logic [32:0]       count_q;
	logic [52:0]       recip_q;
	logic [16:0]       rem_q;
	logic [DAYS_W-1:0] days_q;
	logic [11:0]       yr_q;
	logic [1:0]        m4_q;
	logic [6:0]        m100_q;
	logic [8:0]        m400_q;
	logic [3:0]        mon_q;
	logic [4:0]        hour_q;
	logic [5:0]        min_q;
	logic [11:0]       tgt_year_q;
	logic [3:0]        tgt_mon_q;
	logic [4:0]        tgt_day_q;
	logic [4:0]        tgt_hour_q;
	logic [5:0]        tgt_min_q;
	logic [5:0]        tgt_sec_q;
	logic [PROD_W-1:0] prod_q;
	logic [16:0]       hms_q;

	logic [11:0]       in_year;
	logic [3:0]        in_month;
	logic [4:0]        in_day;
	logic              leap;
	logic [8:0]        ylen;
	logic [4:0]        mlen;
	logic [SUM_W-1:0]  sum;

	assign in_year  = set_word[11:0];
	assign in_month = set_word[15:12];
	assign in_day   = set_word[20:16];

	assign leap    = is_leap(m4_q, m100_q, m400_q);
	assign ylen    = year_len(leap);
	assign mlen    = month_len(mon_q, leap);
	assign sum     = {1'b0, prod_q} + SUM_W'(hms_q);

	assign status.set_year_more = yr_q < tgt_year_q;
	assign status.set_mon_more  = mon_q < tgt_mon_q;
	assign status.year_fit      = days_q >= DAYS_W'(ylen);
	assign status.mon_fit       = (mon_q < 4'd12) && (days_q >= DAYS_W'(mlen));
	assign status.hour_fit      = rem_q >= HOUR_SECONDS;
	assign status.min_fit       = rem_q >= MIN_SECONDS;

	assign total_seconds = count_q;
	assign out_year      = yr_q;
	assign out_month     = mon_q;
	assign out_day       = days_q[4:0] + 5'd1;
	assign out_hour      = hour_q;
	assign out_minute    = min_q;
	assign out_second    = rem_q[5:0];

	// the only register with a reset value the user sees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd)
				CMD_SUM: count_q <= (sum > SUM_W'(COUNT_TOP)) ? COUNT_TOP : 33'(sum);
				CMD_INC: begin
					if (count_q != COUNT_TOP) count_q <= count_q + 33'd1;
				end
				CMD_DEC: count_q <= (count_q == '0) ? COUNT_TOP - 33'd1 : count_q - 33'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd) inside
			CMD_LOAD: begin
				if (in_year < EPOCH_YEAR) tgt_year_q <= EPOCH_YEAR;
				else if (in_year > YEAR_LAST) tgt_year_q <= YEAR_LAST;
				else tgt_year_q <= in_year;
				if (in_month == 4'd0) tgt_mon_q <= 4'd1;
				else if (in_month > 4'd12) tgt_mon_q <= 4'd12;
				else tgt_mon_q <= in_month;
				tgt_day_q  <= (in_day == 5'd0) ? 5'd1 : in_day;
				tgt_hour_q <= set_word[25:21];
				tgt_min_q  <= set_word[31:26];
				tgt_sec_q  <= set_word[37:32];
				days_q <= '0;
				yr_q   <= EPOCH_YEAR;
				m4_q   <= EPOCH_MOD4;
				m100_q <= EPOCH_MOD100;
				m400_q <= EPOCH_MOD400;
				mon_q  <= 4'd1;
			end
			CMD_SET_YEAR, CMD_DEC_YEAR: begin
				if (cmd == CMD_SET_YEAR) days_q <= days_q + DAYS_W'(ylen);
				else days_q <= days_q - DAYS_W'(ylen);
				yr_q   <= yr_q + 12'd1;
				m4_q   <= m4_q + 2'd1;
				m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
				m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
			end
			CMD_SET_MON: begin
				days_q <= days_q + DAYS_W'(mlen);
				mon_q  <= mon_q + 4'd1;
			end
			CMD_DEC_MON: begin
				days_q <= days_q - DAYS_W'(mlen);
				mon_q  <= mon_q + 4'd1;
			end
			CMD_SET_DAY: days_q <= days_q + DAYS_W'(tgt_day_q - 5'd1);
			CMD_MUL: begin
				prod_q <= PROD_W'(days_q) * PROD_W'(DAY_SECONDS);
				hms_q  <= 17'(tgt_hour_q) * HOUR_SECONDS + 17'(tgt_min_q) * MIN_SECONDS
					+ 17'(tgt_sec_q);
			end
			// day length is 128 * 675: drop the 7 low bits, then multiply by the reciprocal
			CMD_DIV_INIT: begin
				recip_q <= 53'(count_q[32:7]) * 53'(DAY_RECIP);
				yr_q   <= EPOCH_YEAR;
				m4_q   <= EPOCH_MOD4;
				m100_q <= EPOCH_MOD100;
				m400_q <= EPOCH_MOD400;
				mon_q  <= 4'd1;
				hour_q <= '0;
				min_q  <= '0;
			end
			CMD_DIV_STEP: days_q <= DAYS_W'(recip_q[DAY_RECIP_SHIFT +: 17]);
			CMD_DIV_END: rem_q <= 17'(count_q - 33'(days_q) * 33'(DAY_SECONDS));
			CMD_HOUR: begin
				rem_q  <= rem_q - HOUR_SECONDS;
				hour_q <= hour_q + 5'd1;
			end
			CMD_MIN: begin
				rem_q <= rem_q - MIN_SECONDS;
				min_q <= min_q + 6'd1;
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/ecc_ctrl.sv -----
module ecc_ctrl
	import ecc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_func,
	input  logic       out_free,
	input  dp_status_t status,
	output ctrl_out_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl.cmd      = CMD_NONE;
		ctl.in_ready = 1'b0;
		ctl.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.in_ready = 1'b1;
				if (in_valid) begin
					unique case (func_t'(in_func))
						FUNC_SET: begin
							ctl.cmd = CMD_LOAD;
							state_d = ST_SET_YEAR;
						end
						FUNC_INC: begin
							ctl.cmd = CMD_INC;
							state_d = ST_DIV_INIT;
						end
						FUNC_DEC: begin
							ctl.cmd = CMD_DEC;
							state_d = ST_DIV_INIT;
						end
						FUNC_READ: state_d = ST_DIV_INIT;
						default: ;
					endcase
				end
			end
			ST_SET_YEAR: begin
				if (status.set_year_more) ctl.cmd = CMD_SET_YEAR;
				else state_d = ST_SET_MON;
			end
			ST_SET_MON: begin
				if (status.set_mon_more) begin
					ctl.cmd = CMD_SET_MON;
				end else begin
					ctl.cmd = CMD_SET_DAY;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				ctl.cmd = CMD_MUL;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				ctl.cmd = CMD_SUM;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				ctl.cmd = CMD_DIV_INIT;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.cmd = CMD_DIV_STEP;
				state_d = ST_DIV_END;
			end
			ST_DIV_END: begin
				ctl.cmd = CMD_DIV_END;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				if (status.year_fit) ctl.cmd = CMD_DEC_YEAR;
				else state_d = ST_MON;
			end
			ST_MON: begin
				if (status.mon_fit) ctl.cmd = CMD_DEC_MON;
				else state_d = ST_HOUR;
			end
			ST_HOUR: begin
				if (status.hour_fit) ctl.cmd = CMD_HOUR;
				else state_d = ST_MIN;
			end
			ST_MIN: begin
				if (status.min_fit) ctl.cmd = CMD_MIN;
				else state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/epoch_calendar_converter.sv -----
// Sequence: read/increment/decrement run divide init, step and end, then walk years, months,
//   hours and minutes; set first walks target years and months, then multiplies, sums and divides.
// Throughput: one word at a time; the next word is taken the cycle after the result enters the
//   output register, which holds it until the sink takes it. The year walk sets it.
// Reset (arst_n low, asynchronous): counter cleared to zero, controller idle, output empty.
module epoch_calendar_converter
	import ecc_pkg::*;
#(
	parameter int YEAR_SPAN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// set_year[11:0], set_month[15:12], set_day[20:16], set_hour[25:21],
	// set_minute[31:26], set_second[37:32], zero fill[39:38]
	input  logic [39:0] s_tdata,
	// func[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// total_seconds[32:0], out_year[44:33], out_month[48:45], out_day[53:49],
	// out_hour[58:54], out_minute[64:59], out_second[70:65], zero fill[71]
	output logic [71:0] m_tdata
);

	ctrl_out_t   ctl;
	dp_status_t  status;
	logic        out_free;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [32:0] total_seconds;
	logic [11:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [4:0]  out_hour;
	logic [5:0]  out_minute;
	logic [5:0]  out_second;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = ctl.in_ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ecc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.out_free (out_free),
		.status   (status),
		.ctl      (ctl)
	);

	ecc_datapath #(
		.YEAR_SPAN (YEAR_SPAN)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl.cmd),
		.set_word      (s_tdata),
		.status        (status),
		.total_seconds (total_seconds),
		.out_year      (out_year),
		.out_month     (out_month),
		.out_day       (out_day),
		.out_hour      (out_hour),
		.out_minute    (out_minute),
		.out_second    (out_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			m_tdata_q <= {1'b0, out_second, out_minute, out_hour, out_day, out_month,
				out_year, total_seconds};
		end
	end

endmodule
